### hw/rtl/ptk_pkg.sv
// Shared types, constants and helpers for the periodic tick accountant.
// No dependencies.
package ptk_pkg;

	localparam int unsigned PERIOD_W = 40;
	localparam int unsigned TIME_W   = 63;
	localparam int unsigned ACC_W    = 64;
	localparam int unsigned PEND_W   = 16;

	localparam logic [PERIOD_W-1:0] MIN_PERIOD = 40'd100000;
	localparam int unsigned MAX_BURST_DEF  = 50;
	localparam int unsigned GIVE_UP_NS_DEF = 500000000;

	localparam logic [1:0] CMD_START    = 2'd0;
	localparam logic [1:0] CMD_EXPIRY   = 2'd1;
	localparam logic [1:0] CMD_ACK      = 2'd2;
	localparam logic [1:0] CMD_COLLAPSE = 2'd3;

	localparam logic [1:0] MODE_SINGLE = 2'd1;
	localparam logic [1:0] MODE_REPLAY = 2'd2;

	localparam logic [1:0] REG_TICK     = 2'd0;
	localparam logic [1:0] REG_COALESCE = 2'd1;
	localparam logic [1:0] REG_MODE     = 2'd2;

	typedef struct packed {
		logic [PERIOD_W-1:0] tick_period;
		logic [PERIOD_W-1:0] coal_period;
		logic [1:0]          missed_mode;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] last_tick_time;
		logic              gave_up;
		logic              rearm;
		logic [TIME_W-1:0] next_deadline;
		logic [PEND_W-1:0] pending_count;
	} res_t;

	function automatic logic [PEND_W-1:0] add_pending(input logic [PEND_W-1:0] pend,
		input logic [ACC_W-1:0] n);
		logic [ACC_W-1:0] room;
		room = ACC_W'({PEND_W{1'b1}} - pend);
		if (n >= room) begin
			return {PEND_W{1'b1}};
		end
		return pend + n[PEND_W-1:0];
	endfunction

endpackage

### hw/rtl/ptk_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ptk_pkg.
module ptk_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ptk_pkg::ACC_W-1:0]      dividend,
	input  logic [ptk_pkg::PERIOD_W-1:0]   divisor,
	output logic                           done,
	output logic [ptk_pkg::ACC_W-1:0]      quot,
	output logic [ptk_pkg::PERIOD_W-1:0]   rem
);
	import ptk_pkg::*;

	localparam int unsigned CNT_W = $clog2(ACC_W + 1);

	logic [ACC_W-1:0]    dvd_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W-1:0] dsr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [PERIOD_W:0]   trial;
	logic                qbit;

	assign trial = {rem_q, dvd_q[ACC_W-1]};
	assign qbit  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ACC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ACC_W-2:0], qbit};
			rem_q <= qbit ? PERIOD_W'(trial - {1'b0, dsr_q}) : trial[PERIOD_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;
endmodule

### hw/rtl/ptk_core.sv
// Accounting sequencer: timer state and the missed-tick steps.
// Depends on ptk_pkg and ptk_div.
module ptk_core #(
	parameter int unsigned MAX_BURST  = ptk_pkg::MAX_BURST_DEF,
	parameter int unsigned GIVE_UP_NS = ptk_pkg::GIVE_UP_NS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ptk_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    command,
	input  logic [ptk_pkg::TIME_W-1:0]    now,
	input  logic [ptk_pkg::TIME_W-1:0]    gtime,
	input  logic [ptk_pkg::PERIOD_W-1:0]  start_delay,
	output logic                          res_valid,
	input  logic                          res_ready,
	output ptk_pkg::res_t                 res
);
	import ptk_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PM, ST_DIV1, ST_CAP, ST_DIV2, ST_INJ, ST_DL, ST_DIV3, ST_POST, ST_DONE
	} state_t;

	state_t              state_q;
	logic [TIME_W-1:0]   deadline_q, first_q, ldg_q, now_q;
	logic [ACC_W-1:0]    ta_q;
	logic [PEND_W-1:0]   pend_q;
	logic                flag_q, col_q, rearm_q, gave_q;
	logic [ACC_W-1:0]    x_q, miss_q, mp_q, cap_q, capp_q;
	logic                div_start_q;
	logic [ACC_W-1:0]    div_a_q;
	logic [PERIOD_W-1:0] div_b_q;

	logic                div_done;
	logic [ACC_W-1:0]    div_quot;
	logic [PERIOD_W-1:0] div_rem;

	logic [PERIOD_W-1:0] p, sp;
	logic [ACC_W-1:0]    elapsed, msp, inj, injp, mp_now;
	logic [ACC_W:0]      start_sum, nd;
	logic [PEND_W-1:0]   pend_dec;

	assign p  = (cfg.tick_period < MIN_PERIOD) ? MIN_PERIOD : cfg.tick_period;
	assign sp = (cfg.coal_period > p) ? cfg.coal_period : p;
	assign elapsed   = ACC_W'({1'b0, now_q}) - ACC_W'({1'b0, first_q}) + ACC_W'(p);
	assign msp       = ACC_W'(sp) * ACC_W'(MAX_BURST);
	assign inj       = (miss_q > cap_q) ? cap_q : miss_q;
	assign injp      = (miss_q > cap_q) ? capp_q : mp_q;
	assign mp_now    = x_q - ACC_W'(div_rem);
	assign start_sum = (ACC_W + 1)'(now) + (ACC_W + 1)'(start_delay);
	assign nd        = (ACC_W + 1)'(now_q) - (ACC_W + 1)'(div_rem) + (ACC_W + 1)'(sp);
	assign pend_dec  = pend_q - 1'b1;

	ptk_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			deadline_q  <= '0;
			first_q     <= '0;
			ta_q        <= '0;
			pend_q      <= '0;
			ldg_q       <= '0;
			flag_q      <= 1'b0;
			col_q       <= 1'b0;
			rearm_q     <= 1'b0;
			gave_q      <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						now_q   <= now;
						rearm_q <= 1'b0;
						gave_q  <= 1'b0;
						col_q   <= 1'b0;
						state_q <= ST_DONE;
						case (command)
							CMD_START: begin
								ta_q    <= '0;
								pend_q  <= '0;
								flag_q  <= 1'b0;
								ldg_q   <= gtime;
								deadline_q <= (|start_sum[ACC_W:TIME_W]) ? {TIME_W{1'b1}}
									: start_sum[TIME_W-1:0];
								first_q <= (|start_sum[ACC_W:TIME_W]) ? {TIME_W{1'b1}}
									: start_sum[TIME_W-1:0];
								rearm_q <= 1'b1;
							end
							CMD_EXPIRY: begin
								state_q <= ST_PM;
							end
							CMD_ACK: begin
								if (pend_q != '0) begin
									if (cfg.missed_mode == MODE_SINGLE || flag_q) begin
										ldg_q   <= gtime;
										col_q   <= 1'b1;
										state_q <= ST_PM;
									end else begin
										ldg_q  <= TIME_W'(ldg_q + TIME_W'(p));
										pend_q <= pend_dec;
										if (pend_dec == '0) begin
											state_q <= ST_PM;
										end
									end
								end
							end
							default: begin
								flag_q <= 1'b1;
							end
						endcase
					end
				end
				ST_PM: begin
					if (deadline_q >= now_q) begin
						state_q <= ST_POST;
					end else begin
						x_q <= (now_q >= first_q && elapsed > ta_q) ? elapsed - ta_q : '0;
						div_a_q <= (now_q >= first_q && elapsed > ta_q) ? elapsed - ta_q : '0;
						div_b_q <= p;
						div_start_q <= 1'b1;
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						miss_q <= div_quot;
						mp_q   <= mp_now;
						if (mp_now > ACC_W'(GIVE_UP_NS)) begin
							pend_q  <= add_pending(pend_q, ACC_W'(1));
							ta_q    <= ta_q + mp_now;
							gave_q  <= 1'b1;
							state_q <= ST_DL;
						end else begin
							state_q <= ST_CAP;
						end
					end
				end
				ST_CAP: begin
					if (cfg.missed_mode == MODE_SINGLE) begin
						cap_q   <= ACC_W'(1);
						capp_q  <= ACC_W'(p);
						state_q <= ST_INJ;
					end else if (sp > p) begin
						div_a_q <= msp;
						div_b_q <= p;
						div_start_q <= 1'b1;
						state_q <= ST_DIV2;
					end else begin
						cap_q   <= ACC_W'(MAX_BURST);
						capp_q  <= ACC_W'(p) * ACC_W'(MAX_BURST);
						state_q <= ST_INJ;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						cap_q   <= div_quot;
						capp_q  <= msp - ACC_W'(div_rem);
						state_q <= ST_INJ;
					end
				end
				ST_INJ: begin
					pend_q  <= add_pending(pend_q, inj);
					ta_q    <= ta_q + ((cfg.missed_mode == MODE_REPLAY) ? injp : mp_q);
					state_q <= ST_DL;
				end
				ST_DL: begin
					div_a_q <= ACC_W'(now_q - deadline_q);
					div_b_q <= sp;
					div_start_q <= 1'b1;
					state_q <= ST_DIV3;
				end
				ST_DIV3: begin
					if (div_done) begin
						deadline_q <= (|nd[ACC_W:TIME_W]) ? {TIME_W{1'b1}} : nd[TIME_W-1:0];
						state_q    <= ST_POST;
					end
				end
				ST_POST: begin
					if (col_q) begin
						pend_q  <= '0;
						flag_q  <= 1'b0;
						rearm_q <= 1'b1;
					end else begin
						rearm_q <= (pend_q == '0);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res.pending_count  = pend_q;
	assign res.next_deadline  = deadline_q;
	assign res.rearm          = rearm_q;
	assign res.gave_up        = gave_q;
	assign res.last_tick_time = ldg_q;
endmodule

### hw/rtl/periodic_tick_accountant.sv
// Top level: register port, input word decode and output register.
// Depends on ptk_pkg and ptk_core.
//
// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tdata, s_tuser (command)
// m       | out | m_tvalid/m_tready  | m_tdata
// apb     | in  | psel/penable/pready| paddr, pwdata, prdata
//
// Start, collapse and plain ack words go straight to the result; expiry words, collapsing
// acks and acks that clear the last pending tick also pass the deadline check, and when
// the deadline has passed they take two or three passes of the bit-serial divider. One
// word is in work at a time; a finished result waits in the output register while the
// next word is taken. Reset clears all timer state.
module periodic_tick_accountant #(
	parameter int unsigned MAX_BURST  = ptk_pkg::MAX_BURST_DEF,
	parameter int unsigned GIVE_UP_NS = ptk_pkg::GIVE_UP_NS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [167:0] s_tdata,  // now[62:0], gtime[125:63], start_delay[165:126]
	input  logic [1:0]   s_tuser,  // command[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,  // pending_count, next_deadline, rearm, gave_up, last_tick_time
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);
	import ptk_pkg::*;

	cfg_t          cfg_q;
	logic          m_tvalid_q;
	logic [143:0]  m_tdata_q;
	logic          res_valid, res_ready;
	res_t          res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_period <= MIN_PERIOD;
			cfg_q.coal_period <= '0;
			cfg_q.missed_mode <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[4:3])
				REG_TICK:     cfg_q.tick_period <= pwdata[PERIOD_W-1:0];
				REG_COALESCE: cfg_q.coal_period <= pwdata[PERIOD_W-1:0];
				REG_MODE:     cfg_q.missed_mode <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_TICK:     prdata = 64'(cfg_q.tick_period);
			REG_COALESCE: prdata = 64'(cfg_q.coal_period);
			REG_MODE:     prdata = 64'(cfg_q.missed_mode);
			default:      prdata = '0;
		endcase
	end

	ptk_core #(
		.MAX_BURST  (MAX_BURST),
		.GIVE_UP_NS (GIVE_UP_NS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.command     (s_tuser),
		.now         (s_tdata[62:0]),
		.gtime       (s_tdata[125:63]),
		.start_delay (s_tdata[165:126]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
endmodule

### hw/rtl/ptk_chk.sv
// Port-level checks for the periodic tick accountant, bound to the top level.
// Depends on periodic_tick_accountant.
module ptk_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata,
	input logic         psel,
	input logic         pready
);
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is in work");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a word in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("register port stalled");
endmodule

bind periodic_tick_accountant ptk_chk u_ptk_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.psel     (psel),
	.pready   (pready)
);

### tb/tb_top.sv
// Testbench for periodic_tick_accountant: directed table, then random timer traffic
// over several register settings, checked against an in-bench tick accounting model.
// Depends on ptk_pkg and the periodic_tick_accountant RTL.
module tb_top;
	import ptk_pkg::*;

	localparam logic [63:0] T63 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [39:0] T40 = 40'hFF_FFFF_FFFF;
	localparam int ITEMS_PER_PHASE = 300;

	typedef struct {
		logic [1:0]  cmd;
		logic [62:0] now;
		logic [62:0] gt;
		logic [39:0] dly;
		bit          typed;
		logic [15:0] w_pend;
		logic [62:0] w_dl;
		bit          w_rearm;
		bit          w_gave;
		logic [62:0] w_ltt;
	} dir_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [167:0] s_tdata;  // now, gtime, start_delay, zero fill
	logic [1:0]   s_tuser;  // command
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;  // pending_count, next_deadline, rearm, gave_up, last_tick_time
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [4:0]   paddr;
	logic [63:0]  pwdata;
	logic [63:0]  prdata;
	logic         pready;

	periodic_tick_accountant DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// model of the timer accounting
	logic [39:0] cfg_tick;
	logic [39:0] cfg_coal;
	logic [1:0]  cfg_mode;
	logic [63:0] tm_deadline;
	logic [63:0] tm_first;
	logic [63:0] tm_accounted;
	logic [15:0] tm_pending;
	logic [62:0] tm_last_gt;
	bit          tm_collapse;

	res_t expected_words[$];
	int   errors;
	bit   quiet;
	int   hold_asks;
	int   hold_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [63:0] tick_len();
		return (cfg_tick < MIN_PERIOD) ? 64'(MIN_PERIOD) : 64'(cfg_tick);
	endfunction

	function automatic logic [63:0] grid_len();
		logic [63:0] p;
		p = tick_len();
		return (cfg_coal != 0 && 64'(cfg_coal) > p) ? 64'(cfg_coal) : p;
	endfunction

	function automatic void bump_pending(input logic [63:0] n);
		if (n >= 64'(16'hFFFF - tm_pending))
			tm_pending = 16'hFFFF;
		else
			tm_pending = tm_pending + n[15:0];
	endfunction

	function automatic bit catch_up(input logic [63:0] now);
		logic [63:0] p, sp, missed, elapsed, lost, cap, inj, nd;
		p = tick_len();
		sp = grid_len();
		missed = 0;
		if (tm_deadline >= now)
			return 1'b0;
		if (now >= tm_first) begin
			elapsed = now - tm_first + p;
			if (elapsed > tm_accounted)
				missed = (elapsed - tm_accounted) / p;
		end
		lost = missed * p;
		if (lost > 64'(GIVE_UP_NS_DEF)) begin
			bump_pending(1);
			tm_accounted += lost;
		end else begin
			if (cfg_mode == MODE_SINGLE)
				cap = 1;
			else if (sp > p)
				cap = 64'(MAX_BURST_DEF) * sp / p;
			else
				cap = 64'(MAX_BURST_DEF);
			inj = (missed > cap) ? cap : missed;
			bump_pending(inj);
			tm_accounted += p * ((cfg_mode == MODE_REPLAY) ? inj : missed);
		end
		nd = tm_deadline + (1 + (now - tm_deadline) / sp) * sp;
		tm_deadline = (nd > T63) ? T63 : nd;
		return lost > 64'(GIVE_UP_NS_DEF);
	endfunction

	function automatic res_t tally_word(input logic [1:0] cmd, input logic [62:0] now,
		input logic [62:0] gt, input logic [39:0] dly);
		res_t r;
		bit rearm, gave;
		rearm = 0;
		gave = 0;
		case (cmd)
			CMD_START: begin
				tm_accounted = 0;
				tm_pending = 0;
				tm_collapse = 0;
				tm_last_gt = gt;
				tm_deadline = 64'(now) + 64'(dly);
				if (tm_deadline > T63)
					tm_deadline = T63;
				tm_first = tm_deadline;
				rearm = 1;
			end
			CMD_EXPIRY: begin
				gave = catch_up(64'(now));
				rearm = (tm_pending == 0);
			end
			CMD_ACK: begin
				if (tm_pending != 0) begin
					if (cfg_mode == MODE_SINGLE || tm_collapse) begin
						tm_last_gt = gt;
						gave = catch_up(64'(now));
						tm_pending = 0;
						tm_collapse = 0;
						rearm = 1;
					end else begin
						tm_last_gt = tm_last_gt + 63'(tick_len());
						tm_pending--;
						if (tm_pending == 0) begin
							gave = catch_up(64'(now));
							rearm = (tm_pending == 0);
						end
					end
				end
			end
			default: tm_collapse = 1;
		endcase
		r.pending_count = tm_pending;
		r.next_deadline = tm_deadline[62:0];
		r.rearm = rearm;
		r.gave_up = gave;
		r.last_tick_time = tm_last_gt;
		return r;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// result side: checking, random stalls and requested holds
	initial begin
		int stall_left;
		int hold_left;
		res_t got, want;
		m_tready = 1'b0;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata);
				if (expected_words.size() == 0) begin
					$display("%0t unexpected word", $realtime);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (got.pending_count !== want.pending_count)
						report("pending_count", 64'(got.pending_count), 64'(want.pending_count));
					if (got.next_deadline !== want.next_deadline)
						report("next_deadline", 64'(got.next_deadline), 64'(want.next_deadline));
					if (got.rearm !== want.rearm)
						report("rearm", 64'(got.rearm), 64'(want.rearm));
					if (got.gave_up !== want.gave_up)
						report("gave_up", 64'(got.gave_up), 64'(want.gave_up));
					if (got.last_tick_time !== want.last_tick_time)
						report("last_tick_time", 64'(got.last_tick_time),
							64'(want.last_tick_time));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_done < hold_asks) begin
				hold_done++;
				hold_left = 700;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 5'(idx) << 3;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TICK:     cfg_tick = val[39:0];
			REG_COALESCE: cfg_coal = val[39:0];
			default:      cfg_mode = val[1:0];
		endcase
	endtask

	task automatic drain();
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_word(input logic [1:0] cmd, input logic [62:0] now,
		input logic [62:0] gt, input logic [39:0] dly, input bit typed, input res_t want);
		res_t r;
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {2'b00, dly, gt, now};
		do @(posedge clk); while (!s_tready);
		r = tally_word(cmd, now, gt, dly);
		expected_words.push_back(typed ? want : r);
	endtask

	function automatic logic [62:0] rand63();
		return {$urandom(), $urandom()} & T63;
	endfunction

	initial begin
		dir_row_t rows[];
		res_t w;
		logic [63:0] clock_ns, p, adv;
		logic [62:0] nv;
		logic [39:0] dly;
		int pick, flood;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_START;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		quiet = 0;
		hold_asks = 0;
		hold_done = 0;
		cfg_tick = MIN_PERIOD;
		cfg_coal = 0;
		cfg_mode = 0;
		tm_deadline = 0;
		tm_first = 0;
		tm_accounted = 0;
		tm_pending = 0;
		tm_last_gt = 0;
		tm_collapse = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{CMD_ACK,      63'd0, 63'd0, 40'd0, 1, 16'd0, 63'd0, 0, 0, 63'd0},
			'{CMD_COLLAPSE, 63'd0, 63'd0, 40'd0, 1, 16'd0, 63'd0, 0, 0, 63'd0},
			'{CMD_EXPIRY,   63'd0, 63'd0, 40'd0, 1, 16'd0, 63'd0, 1, 0, 63'd0},
			'{CMD_START, T63[62:0], T63[62:0], T40, 1, 16'd0, T63[62:0], 1, 0, T63[62:0]},
			'{CMD_EXPIRY, T63[62:0], 63'd0, 40'd0, 1, 16'd0, T63[62:0], 1, 0, T63[62:0]},
			'{CMD_START,    63'd0, 63'd0, 40'd1000, 1, 16'd0, 63'd1000, 1, 0, 63'd0},
			'{CMD_EXPIRY,   63'd301001, 63'd0, 40'd0, 0, 0, 0, 0, 0, 0},
			'{CMD_ACK,      63'd301002, 63'd5, 40'd0, 0, 0, 0, 0, 0, 0},
			'{CMD_ACK,      63'd301003, 63'd6, 40'd0, 0, 0, 0, 0, 0, 0},
			'{CMD_COLLAPSE, 63'd301004, 63'd7, 40'd0, 0, 0, 0, 0, 0, 0},
			'{CMD_ACK,      63'd501004, 63'd12345, 40'd0, 0, 0, 0, 0, 0, 0},
			'{CMD_EXPIRY,   63'd2000000000, 63'd0, 40'd0, 0, 0, 0, 0, 0, 0},
			'{CMD_ACK,      63'd2000000001, 63'd9, 40'd0, 0, 0, 0, 0, 0, 0},
			'{CMD_EXPIRY,   63'd2007000000, 63'd0, 40'd0, 0, 0, 0, 0, 0, 0},
			'{CMD_ACK,      63'd2007000001, 63'd0, 40'd0, 0, 0, 0, 0, 0, 0},
			'{CMD_EXPIRY,   T63[62:0], 63'd0, 40'd0, 0, 0, 0, 0, 0, 0},
			'{CMD_START,    63'd5, 63'd77, 40'd0, 0, 0, 0, 0, 0, 0},
			'{CMD_EXPIRY,   63'd5, 63'd0, 40'd0, 0, 0, 0, 0, 0, 0},
			'{CMD_EXPIRY,   63'd6, 63'd0, 40'd0, 0, 0, 0, 0, 0, 0}
		};
		foreach (rows[i]) begin
			w.pending_count = rows[i].w_pend;
			w.next_deadline = rows[i].w_dl;
			w.rearm = rows[i].w_rearm;
			w.gave_up = rows[i].w_gave;
			w.last_tick_time = rows[i].w_ltt;
			send_word(rows[i].cmd, rows[i].now, rows[i].gt, rows[i].dly, rows[i].typed, w);
		end

		for (int ph = 0; ph < 6; ph++) begin
			s_tvalid <= 1'b0;
			drain();
			case (ph)
				0: begin reg_write(REG_TICK, 64'd100000); reg_write(REG_COALESCE, 64'd0);
					reg_write(REG_MODE, 64'(MODE_REPLAY)); end
				1: begin reg_write(REG_TICK, 64'd1000000); reg_write(REG_COALESCE, 64'd5000000);
					reg_write(REG_MODE, 64'(MODE_SINGLE)); end
				2: begin reg_write(REG_TICK, 64'd100000); reg_write(REG_COALESCE, 64'(T40));
					reg_write(REG_MODE, 64'd0); end
				3: begin reg_write(REG_TICK, 64'd50); reg_write(REG_COALESCE, 64'd250000);
					reg_write(REG_MODE, 64'd3); end
				4: begin reg_write(REG_TICK, 64'(T40)); reg_write(REG_COALESCE, 64'(T40));
					reg_write(REG_MODE, 64'(MODE_REPLAY)); end
				default: begin reg_write(REG_TICK, 64'd10000000);
					reg_write(REG_COALESCE, 64'd1000); reg_write(REG_MODE, 64'd0); end
			endcase
			if (ph == 5)
				quiet = 1;
			p = tick_len();
			clock_ns = 0;
			flood = 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 1 && n == 100)
					hold_asks++;
				pick = $urandom_range(0, 99);
				if (flood > 0) begin
					flood--;
					clock_ns += 64'd400000000;
					send_word(CMD_EXPIRY, clock_ns[62:0], rand63(), 40'd0, 0, w);
				end else if (pick < 3) begin
					flood = 16;
					send_word(CMD_START, clock_ns[62:0], rand63(), 40'd0, 0, w);
				end else if (pick < 12) begin
					clock_ns = ($urandom_range(0, 1)) ? 64'($urandom()) : 64'(rand63() >> 2);
					dly = ($urandom_range(0, 3) == 0) ? 40'({$urandom(), $urandom()}) :
						40'($urandom_range(0, 5) * p);
					send_word(CMD_START, clock_ns[62:0], rand63(), dly, 0, w);
				end else if (pick < 50) begin
					case ($urandom_range(0, 3))
						0: adv = 64'($urandom_range(0, 2000)) * p / 1000;
						1: adv = 64'($urandom_range(0, 80)) * p + $urandom_range(0, 999);
						2: adv = 64'($urandom_range(0, 1200)) * 1000000;
						default: adv = 64'($urandom_range(0, 3)) * p;
					endcase
					clock_ns += adv;
					if (clock_ns > T63)
						clock_ns = T63;
					send_word(CMD_EXPIRY, clock_ns[62:0], rand63(), 40'd0, 0, w);
				end else if (pick < 85) begin
					clock_ns += $urandom_range(0, 3) * p / 2;
					if (clock_ns > T63)
						clock_ns = T63;
					send_word(CMD_ACK, clock_ns[62:0], rand63(), 40'($urandom()), 0, w);
				end else if (pick < 91) begin
					send_word(CMD_COLLAPSE, clock_ns[62:0], rand63(), 40'($urandom()), 0, w);
				end else begin
					nv = rand63();
					send_word(2'($urandom()), nv, rand63(), 40'({$urandom(), $urandom()}), 0, w);
				end
			end
		end
		s_tvalid <= 1'b0;
		drain();
		repeat (250) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/ptk_pkg.sv
hw/rtl/ptk_div.sv
hw/rtl/ptk_core.sv
hw/rtl/periodic_tick_accountant.sv
hw/rtl/ptk_chk.sv
tb/tb_top.sv
